@@ rtl/least_loaded_worker_select_macros.svh @@
// ---------------------------------------------------------------------------
// least_loaded_worker_select assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef LEAST_LOADED_WORKER_SELECT_MACROS_SVH
`define LEAST_LOADED_WORKER_SELECT_MACROS_SVH

`ifndef SYNTHESIS
`define LLWS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LLWS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define LLWS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LLWS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

@@ rtl/llws_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llws_pkg
// Shared types and field widths of the least loaded worker selector
// ---------------------------------------------------------------------------
package llws_pkg;

    localparam int CFG_W    = 5;
    localparam int IDX_IN_W = 8;
    localparam int WORKER_W = 4;
    localparam int LOAD_W   = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BIND,
        ST_UREAD,
        ST_UCHECK
    } t_state;

    typedef enum logic [1:0] {
        ALU_LT,
        ALU_INC,
        ALU_DEC
    } t_alu_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK,
        STAT_RANGE,
        STAT_ZERO,
        STAT_SAT
    } t_status;

endpackage

@@ rtl/llws_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llws_ram
// Generic single write port, single read port RAM with registered read
// ---------------------------------------------------------------------------
module llws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/llws_alu.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llws_alu
// Shared count adder: less-than compare, increment and decrement
// ---------------------------------------------------------------------------
module llws_alu #(
    parameter int COUNT_BITS = 16
) (
    input  llws_pkg::t_alu_op        i_op,
    input  logic [COUNT_BITS-1:0]    i_a,
    input  logic [COUNT_BITS-1:0]    i_b,
    output logic [COUNT_BITS-1:0]    o_sum,
    output logic                     o_carry
);
    import llws_pkg::*;

    logic [COUNT_BITS-1:0] opb;
    logic                  cin;
    logic [COUNT_BITS:0]   full;

    // lt: a + ~b + 1, no carry means a < b
    // inc: carry means a was at maximum
    // dec: a + all ones, no carry means a was zero
    always_comb begin
        unique case (i_op)
            ALU_LT: begin
                opb = ~i_b;
                cin = 1'b1;
            end
            ALU_INC: begin
                opb = '0;
                cin = 1'b1;
            end
            ALU_DEC: begin
                opb = '1;
                cin = 1'b0;
            end
            default: begin
                opb = '0;
                cin = 1'b0;
            end
        endcase
    end

    assign full    = {1'b0, i_a} + {1'b0, opb} + {{COUNT_BITS{1'b0}}, cin};
    assign o_sum   = full[COUNT_BITS-1:0];
    assign o_carry = full[COUNT_BITS];

endmodule

@@ rtl/least_loaded_worker_select.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// least_loaded_worker_select
// Least loaded worker selector with per worker binding counters
// ---------------------------------------------------------------------------
// A bind item (tuser 0) picks the active worker with the smallest count, lowest
// index on ties, and bumps its count; an unbind item (tuser 1) decrements the
// count of the worker in tdata. Counts live in a RAM with one read port and
// are compared one per cycle through a single shared adder. A bind scans the
// active workers, then bumps and emits in ST_BIND; an unbind reads in ST_UREAD
// and decrements in ST_UCHECK; the input is not ready meanwhile. Per entry valid
// bits make every count read as zero after reset, so no clearing pass is needed.
// The user writes worker_count via the cfg port only while idle, which the block
// does not enforce. Zero acts as one, values above MAX_WORKERS as MAX_WORKERS.
// Counts saturate (status 3) and unbinding a zero count is refused (status 2).
// ---------------------------------------------------------------------------
module least_loaded_worker_select #(
    parameter int MAX_WORKERS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [llws_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // worker_index
    input  logic [llws_pkg::IDX_IN_W-1:0]           i_s_axis_tdata,
    // mode
    input  logic [0:0]                              i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // chosen_worker, load_after, zero fill
    output logic [23:0]                             o_m_axis_tdata,
    // status
    output logic [llws_pkg::STATUS_W-1:0]           o_m_axis_tuser
);
    import llws_pkg::*;

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int N_W   = $clog2(MAX_WORKERS + 1);

    t_state                 r_state, n_state;
    logic [CFG_W-1:0]       r_worker_count;
    logic [MAX_WORKERS-1:0] r_valid;
    logic [N_W-1:0]         r_scan;
    logic [N_W-1:0]         r_n;
    logic                   r_pend;
    logic                   r_mode;
    logic [IDX_IN_W-1:0]    r_idx;
    logic                   r_in_range;
    logic [IDX_W-1:0]       r_best;
    logic [COUNT_BITS-1:0]  r_best_cnt;
    logic [IDX_W-1:0]       r_rd_addr;
    logic                   r_m_valid;
    logic [WORKER_W-1:0]    r_m_worker;
    t_status                r_m_status;
    logic [LOAD_W-1:0]      r_m_load;

    logic                   s_accept;
    logic                   out_free;
    logic                   s_ready;
    logic                   emit;
    logic                   scan_issue;
    logic                   ram_we;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic [COUNT_BITS-1:0]  ram_q;
    logic [COUNT_BITS-1:0]  cnt_q;
    t_alu_op                alu_op;
    logic [COUNT_BITS-1:0]  alu_a;
    logic [COUNT_BITS-1:0]  alu_sum;
    logic                   alu_carry;
    logic [8:0]             wc9;
    logic [8:0]             act9;
    logic [N_W-1:0]         n_active;
    logic [31:0]            sum32;
    logic [31:0]            best32;
    logic [7:0]             best8;
    logic [WORKER_W-1:0]    res_worker;
    t_status                res_status;
    logic [LOAD_W-1:0]      res_load;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = s_ready;
    assign s_accept        = i_s_axis_tvalid && s_ready;
    assign out_free        = !r_m_valid || i_m_axis_tready;

    // active worker count
    assign wc9  = 9'(r_worker_count);
    assign act9 = (wc9 == 9'd0) ? 9'd1 :
                  (wc9 > 9'(MAX_WORKERS)) ? 9'(MAX_WORKERS) : wc9;
    assign n_active = N_W'(act9);

    assign cnt_q = r_valid[r_rd_addr] ? ram_q : '0;

    llws_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_WORKERS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (alu_sum),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    llws_alu #(
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (r_best_cnt),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = i_s_axis_tuser[0] ? ST_UREAD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!r_pend && (r_scan == r_n)) begin
                    n_state = ST_BIND;
                end
            end
            ST_BIND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_UREAD: begin
                n_state = ST_UCHECK;
            end
            ST_UCHECK: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        emit       = 1'b0;
        scan_issue = 1'b0;
        alu_op     = ALU_LT;
        alu_a      = cnt_q;
        rd_addr    = r_scan[IDX_W-1:0];
        wr_addr    = r_best;
        unique case (r_state)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                scan_issue = (r_scan < r_n);
            end
            ST_BIND: begin
                alu_op = ALU_INC;
                alu_a  = r_best_cnt;
                emit   = out_free;
            end
            ST_UREAD: begin
                rd_addr = r_idx[IDX_W-1:0];
            end
            ST_UCHECK: begin
                alu_op  = ALU_DEC;
                rd_addr = r_idx[IDX_W-1:0];
                wr_addr = r_idx[IDX_W-1:0];
                emit    = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign ram_we = emit && ((r_state == ST_BIND) ? !alu_carry : (r_in_range && alu_carry));

    // result fields
    assign sum32  = 32'(alu_sum);
    assign best32 = 32'(r_best_cnt);
    assign best8  = 8'(r_best);

    always_comb begin
        if (r_state == ST_BIND) begin
            res_worker = best8[WORKER_W-1:0];
            if (alu_carry) begin
                res_status = STAT_SAT;
                res_load   = best32[LOAD_W-1:0];
            end else begin
                res_status = STAT_OK;
                res_load   = sum32[LOAD_W-1:0];
            end
        end else begin
            res_worker = r_idx[WORKER_W-1:0];
            priority if (!r_in_range) begin
                res_status = STAT_RANGE;
                res_load   = '0;
            end else if (!alu_carry) begin
                res_status = STAT_ZERO;
                res_load   = '0;
            end else begin
                res_status = STAT_OK;
                res_load   = sum32[LOAD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_worker_count <= CFG_W'(1);
            r_valid        <= '0;
            r_scan         <= '0;
            r_n            <= N_W'(1);
            r_pend         <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_worker_count <= i_cfg_data;
            end
            if (ram_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (s_accept) begin
                r_scan <= '0;
                r_pend <= 1'b0;
                r_n    <= n_active;
            end else if (r_state == ST_SCAN) begin
                r_pend <= scan_issue;
                if (scan_issue) begin
                    r_scan <= r_scan + N_W'(1);
                end
            end
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= rd_addr;
        if (s_accept) begin
            r_mode     <= i_s_axis_tuser[0];
            r_idx      <= i_s_axis_tdata;
            r_in_range <= ({1'b0, i_s_axis_tdata} < 9'(n_active));
        end
        // first read seeds the minimum, later reads replace it only when smaller
        if ((r_state == ST_SCAN) && r_pend && !r_mode) begin
            if ((r_rd_addr == '0) || !alu_carry) begin
                r_best     <= r_rd_addr;
                r_best_cnt <= cnt_q;
            end
        end
        if (emit) begin
            r_m_worker <= res_worker;
            r_m_status <= res_status;
            r_m_load   <= res_load;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {4'b0000, r_m_load, r_m_worker};
    assign o_m_axis_tuser  = r_m_status;

`include "least_loaded_worker_select_macros.svh"

    `LLWS_ASSERT_NEVER(a_scan_bound, i_clk, i_rst_n, r_scan > r_n, "scan ran past active workers")
    `LLWS_ASSERT_NEVER(a_write_emit, i_clk, i_rst_n, ram_we && !emit, "count written without item")
    `LLWS_ASSERT_IMPL(a_zero_load, i_clk, i_rst_n, r_m_valid && (r_m_status == STAT_ZERO || r_m_status == STAT_RANGE), r_m_load == '0, "refused unbind with nonzero load")

endmodule
